// File: hw/rtl/fjr_pkg.sv
`timescale 1ns / 1ps
package fjr_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ANGLE_SHIFT     = 32 - ANGLE_FRAC_BITS;

  // pi/9 and pi/18 scaled by 2^32, rounded to the angle format
  localparam logic [63:0] BACKOFF_Q32 = 64'd1499226412;
  localparam logic [63:0] DITHER_Q32  = 64'd749613206;
  localparam logic [31:0] BACKOFF_STEP =
    32'((BACKOFF_Q32 + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT);
  localparam logic [31:0] DITHER_STEP =
    32'((DITHER_Q32 + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT);

  localparam int TORQUE_W = 16;
  localparam int ANGLE_W  = 32;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  typedef logic signed [TORQUE_W-1:0] torque_t;
  typedef logic signed [ANGLE_W-1:0]  angle_t;

  typedef enum logic [2:0] {
    ST_NORMAL        = 3'd0,
    ST_SUSPECT       = 3'd1,
    ST_BACKOFF_SETUP = 3'd2,
    ST_BACKOFF       = 3'd3,
    ST_RECOVERY      = 3'd4,
    ST_FAULT         = 3'd5
  } jam_state_t;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_ANGLE     = 2'd1,
    MODE_OPEN_ZERO = 2'd2
  } drive_mode_t;

  typedef enum logic [1:0] {
    DP_MONITOR = 2'd0,
    DP_OUT     = 2'd1,
    DP_BACK    = 2'd2
  } dither_phase_t;

  typedef enum logic [2:0] {
    REG_TORQUE_THRESHOLD = 3'd0,
    REG_SUSPECT_TICKS    = 3'd1,
    REG_BACKOFF_TICKS    = 3'd2,
    REG_FAULT_HOLD_TICKS = 3'd3,
    REG_DITHER_TICKS     = 3'd4,
    REG_LOW_COUNT_LIMIT  = 3'd5,
    REG_HIGH_COUNT_LIMIT = 3'd6,
    REG_DITHER_LIMIT     = 3'd7
  } reg_index_t;

  localparam logic [14:0] RST_TORQUE_THRESHOLD = 15'd8000;
  localparam logic [15:0] RST_SUSPECT_TICKS    = 16'd500;
  localparam logic [15:0] RST_BACKOFF_TICKS    = 16'd1000;
  localparam logic [15:0] RST_FAULT_HOLD_TICKS = 16'd2000;
  localparam logic [15:0] RST_DITHER_TICKS     = 16'd100;
  localparam logic [7:0]  RST_LOW_COUNT_LIMIT  = 8'd50;
  localparam logic [7:0]  RST_HIGH_COUNT_LIMIT = 8'd200;
  localparam logic [7:0]  RST_DITHER_LIMIT     = 8'd5;

  function automatic logic [7:0] sat8_inc(input logic [7:0] v);
    return (v != 8'hFF) ? v + 8'd1 : v;
  endfunction

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

endpackage

// File: hw/rtl/fjr_if.sv
`timescale 1ns / 1ps
interface fjr_in_if;
  logic              valid;
  logic              ready;
  fjr_pkg::torque_t  motor_torque;
  fjr_pkg::angle_t   motor_angle;

  modport source (output valid, output motor_torque, output motor_angle, input ready);
  modport sink   (input valid, input motor_torque, input motor_angle, output ready);
endinterface

interface fjr_out_if;
  logic                  valid;
  logic                  ready;
  fjr_pkg::jam_state_t   jam_state;
  fjr_pkg::drive_mode_t  drive_mode;
  fjr_pkg::angle_t       target_angle;

  modport source (output valid, output jam_state, output drive_mode, output target_angle,
                  input ready);
  modport sink   (input valid, input jam_state, input drive_mode, input target_angle,
                  output ready);
endinterface

// File: hw/rtl/feeder_jam_recovery_fsm.sv
`timescale 1ns / 1ps
// Feeder jam recovery state machine.
// in_ch carries one control tick per request: motor torque and Q16.16 angle.
// out_ch returns one result per tick: jam state after the tick, drive mode
// and target angle (zero in normal drive mode).
// The cfg_ APB port holds eight 32-bit registers at byte offsets 4*i; writes
// complete in the access cycle, pready is tied high.
// Latency: the result is registered at the edge that accepts the tick and is
// valid in the next cycle. Throughput: one tick per cycle unless out_ch stalls;
// the whole state update is a single pass of compares and 32-bit adds.
// Reset (synchronous, rst_n low) sets the state machine to normal, clears all
// counters and angles, and loads the register defaults.
// When the receiver stalls, the result register holds its contents and
// in_ch.ready drops until the result is taken; a new tick is accepted in the
// same cycle the pending result leaves.
module feeder_jam_recovery_fsm (
  input  logic                       clk,
  input  logic                       rst_n,
  fjr_in_if.sink                     in_ch,
  fjr_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fjr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fjr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fjr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import fjr_pkg::*;

  // configuration registers
  logic [14:0] torque_threshold_r;
  logic [15:0] suspect_ticks_r, backoff_ticks_r, fault_hold_ticks_r, dither_ticks_r;
  logic [7:0]  low_count_limit_r, high_count_limit_r, dither_limit_r;

  reg_index_t cfg_idx;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_index_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      torque_threshold_r <= RST_TORQUE_THRESHOLD;
      suspect_ticks_r    <= RST_SUSPECT_TICKS;
      backoff_ticks_r    <= RST_BACKOFF_TICKS;
      fault_hold_ticks_r <= RST_FAULT_HOLD_TICKS;
      dither_ticks_r     <= RST_DITHER_TICKS;
      low_count_limit_r  <= RST_LOW_COUNT_LIMIT;
      high_count_limit_r <= RST_HIGH_COUNT_LIMIT;
      dither_limit_r     <= RST_DITHER_LIMIT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TORQUE_THRESHOLD: torque_threshold_r <= cfg_pwdata[14:0];
        REG_SUSPECT_TICKS:    suspect_ticks_r    <= cfg_pwdata[15:0];
        REG_BACKOFF_TICKS:    backoff_ticks_r    <= cfg_pwdata[15:0];
        REG_FAULT_HOLD_TICKS: fault_hold_ticks_r <= cfg_pwdata[15:0];
        REG_DITHER_TICKS:     dither_ticks_r     <= cfg_pwdata[15:0];
        REG_LOW_COUNT_LIMIT:  low_count_limit_r  <= cfg_pwdata[7:0];
        REG_HIGH_COUNT_LIMIT: high_count_limit_r <= cfg_pwdata[7:0];
        REG_DITHER_LIMIT:     dither_limit_r     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TORQUE_THRESHOLD: cfg_prdata = {17'd0, torque_threshold_r};
      REG_SUSPECT_TICKS:    cfg_prdata = {16'd0, suspect_ticks_r};
      REG_BACKOFF_TICKS:    cfg_prdata = {16'd0, backoff_ticks_r};
      REG_FAULT_HOLD_TICKS: cfg_prdata = {16'd0, fault_hold_ticks_r};
      REG_DITHER_TICKS:     cfg_prdata = {16'd0, dither_ticks_r};
      REG_LOW_COUNT_LIMIT:  cfg_prdata = {24'd0, low_count_limit_r};
      REG_HIGH_COUNT_LIMIT: cfg_prdata = {24'd0, high_count_limit_r};
      REG_DITHER_LIMIT:     cfg_prdata = {24'd0, dither_limit_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // machine state
  jam_state_t    state_r, state_nxt;
  logic [15:0]   ticks_r, ticks_nxt, ticks_inc;
  logic [31:0]   orig_angle_r, orig_angle_nxt;
  logic [31:0]   base_angle_r, base_angle_nxt;
  logic [31:0]   held_r, held_nxt;
  logic [7:0]    low_cnt_r, low_cnt_nxt, high_cnt_r, high_cnt_nxt;
  dither_phase_t phase_r, phase_nxt;
  logic [15:0]   wait_r, wait_nxt, wait_inc;
  logic [7:0]    attempts_r, attempts_nxt, attempts_inc;
  drive_mode_t   mode;

  // output register
  logic          out_valid_r;
  jam_state_t    out_state_r;
  drive_mode_t   out_mode_r;
  logic [31:0]   out_target_r;

  logic          accept;
  logic [15:0]   mag;
  logic [31:0]   angle;
  logic [19:0]   mag_x10, thr_x3;
  logic          t_low, t_high, t_ge, t_lt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign mag     = in_ch.motor_torque[15] ? 16'(-in_ch.motor_torque) : in_ch.motor_torque;
  assign angle   = in_ch.motor_angle;
  assign mag_x10 = {4'd0, mag} * 20'd10;
  assign thr_x3  = {5'd0, torque_threshold_r} * 20'd3;
  assign t_low   = mag_x10 < thr_x3;
  assign t_high  = mag > {1'b0, torque_threshold_r};
  assign t_ge    = !(mag < {1'b0, torque_threshold_r});
  assign t_lt    = mag < {1'b0, torque_threshold_r};

  assign ticks_inc    = sat16_inc(ticks_r);
  assign wait_inc     = sat16_inc(wait_r);
  assign attempts_inc = sat8_inc(attempts_r);

  always_comb begin
    state_nxt      = state_r;
    ticks_nxt      = ticks_inc;
    orig_angle_nxt = orig_angle_r;
    base_angle_nxt = base_angle_r;
    held_nxt       = held_r;
    low_cnt_nxt    = low_cnt_r;
    high_cnt_nxt   = high_cnt_r;
    phase_nxt      = phase_r;
    wait_nxt       = wait_r;
    attempts_nxt   = attempts_r;
    mode           = MODE_NORMAL;

    unique case (state_r)
      ST_SUSPECT: begin
        if (ticks_inc >= suspect_ticks_r) begin
          state_nxt = ST_BACKOFF_SETUP;
          ticks_nxt = '0;
        end else if (t_lt) begin
          state_nxt = ST_NORMAL;
          ticks_nxt = '0;
        end
      end
      ST_BACKOFF_SETUP: begin
        mode           = MODE_ANGLE;
        orig_angle_nxt = angle;
        held_nxt       = angle + BACKOFF_STEP;
        state_nxt      = ST_BACKOFF;
        ticks_nxt      = '0;
      end
      ST_BACKOFF: begin
        mode = MODE_ANGLE;
        if (ticks_inc >= backoff_ticks_r) begin
          held_nxt  = orig_angle_r;
          state_nxt = ST_RECOVERY;
          ticks_nxt = '0;
        end
      end
      ST_RECOVERY: begin
        mode = MODE_ANGLE;
        unique case (phase_r)
          DP_MONITOR: begin
            if (t_low) begin
              low_cnt_nxt = sat8_inc(low_cnt_r);
              if (low_cnt_nxt > low_count_limit_r) begin
                state_nxt    = ST_NORMAL;
                ticks_nxt    = '0;
                low_cnt_nxt  = '0;
                high_cnt_nxt = '0;
                attempts_nxt = '0;
              end
            end else if (t_high) begin
              high_cnt_nxt = sat8_inc(high_cnt_r);
              if (high_cnt_nxt > high_count_limit_r) begin
                state_nxt    = ST_FAULT;
                ticks_nxt    = '0;
                low_cnt_nxt  = '0;
                high_cnt_nxt = '0;
                attempts_nxt = '0;
              end
            end else begin
              phase_nxt      = DP_OUT;
              wait_nxt       = '0;
              base_angle_nxt = angle;
              held_nxt       = angle + DITHER_STEP;
            end
          end
          DP_OUT: begin
            wait_nxt = wait_inc;
            if (wait_inc > dither_ticks_r) begin
              phase_nxt = DP_BACK;
              wait_nxt  = '0;
              held_nxt  = base_angle_r;
            end
          end
          default: begin
            // return from the dither to the base angle, then judge the torque
            wait_nxt = wait_inc;
            if (wait_inc > dither_ticks_r) begin
              if (t_low) begin
                state_nxt    = ST_NORMAL;
                ticks_nxt    = '0;
                attempts_nxt = '0;
                low_cnt_nxt  = '0;
                high_cnt_nxt = '0;
                phase_nxt    = DP_MONITOR;
              end else if (t_high) begin
                high_cnt_nxt = sat8_inc(high_cnt_r);
                if (high_cnt_nxt > high_count_limit_r) begin
                  // phase, wait and count are not cleared for the next entry
                  state_nxt = ST_FAULT;
                  ticks_nxt = '0;
                end else begin
                  phase_nxt    = DP_MONITOR;
                  attempts_nxt = '0;
                end
              end else begin
                attempts_nxt = attempts_inc;
                if (attempts_inc >= dither_limit_r) begin
                  state_nxt    = ST_FAULT;
                  ticks_nxt    = '0;
                  attempts_nxt = '0;
                  phase_nxt    = DP_MONITOR;
                end else begin
                  phase_nxt      = DP_OUT;
                  wait_nxt       = '0;
                  base_angle_nxt = angle;
                  held_nxt       = angle + DITHER_STEP;
                end
              end
            end
          end
        endcase
      end
      ST_FAULT: begin
        mode     = MODE_OPEN_ZERO;
        held_nxt = angle;
        if (ticks_inc > fault_hold_ticks_r) begin
          state_nxt = ST_NORMAL;
          ticks_nxt = '0;
        end
      end
      default: begin
        state_nxt = ST_NORMAL;
        if (t_ge) begin
          state_nxt = ST_SUSPECT;
          ticks_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_NORMAL;
      ticks_r      <= '0;
      orig_angle_r <= '0;
      base_angle_r <= '0;
      held_r       <= '0;
      low_cnt_r    <= '0;
      high_cnt_r   <= '0;
      phase_r      <= DP_MONITOR;
      wait_r       <= '0;
      attempts_r   <= '0;
    end else if (accept) begin
      state_r      <= state_nxt;
      ticks_r      <= ticks_nxt;
      orig_angle_r <= orig_angle_nxt;
      base_angle_r <= base_angle_nxt;
      held_r       <= held_nxt;
      low_cnt_r    <= low_cnt_nxt;
      high_cnt_r   <= high_cnt_nxt;
      phase_r      <= phase_nxt;
      wait_r       <= wait_nxt;
      attempts_r   <= attempts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_state_r  <= state_nxt;
      out_mode_r   <= mode;
      out_target_r <= (mode == MODE_NORMAL) ? 32'd0 : held_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.jam_state    = out_state_r;
  assign out_ch.drive_mode   = out_mode_r;
  assign out_ch.target_angle = out_target_r;

endmodule
